FILE: hdl/rnct_pkg.sv
`timescale 1ns / 1ps
package rnct_pkg;

  localparam int CMD_BITS       = 3;
  localparam int COORD_BITS     = 12;
  localparam int DIM_BITS       = 13;
  localparam int STATUS_BITS    = 2;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CMD_BITS-1:0] CMD_ADD      = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_REMOVE   = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_ADD_SELF = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_ADD_CHK  = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_REM_CHK  = 3'd4;
  localparam logic [CMD_BITS-1:0] CMD_CLEAR    = 3'd5;

  localparam logic [STATUS_BITS-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_ABSENT = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL   = 2'd2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 13'd480;

  typedef struct packed {
    logic load;
    logic clear;
    logic op_begin;
    logic scan_en;
    logic apply;
    logic finish;
  } ctrl_t;

  typedef struct packed {
    logic is_clear;
    logic op_pending;
    logic scan_done;
  } stat_t;

endpackage

FILE: hdl/rnct_ctrl.sv
`timescale 1ns / 1ps
module rnct_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  rnct_pkg::stat_t stat,
  output rnct_pkg::ctrl_t ctrl
);
  import rnct_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_APPLY  = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    ctrl       = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctrl.load  = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.is_clear) begin
          ctrl.clear = 1'b1;
          state_next = S_RESULT;
        end else if (stat.op_pending) begin
          ctrl.op_begin = 1'b1;
          state_next    = S_SCAN;
        end else begin
          state_next = S_RESULT;
        end
      end
      S_SCAN: begin
        ctrl.scan_en = 1'b1;
        if (stat.scan_done) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        ctrl.apply = 1'b1;
        state_next = S_DECIDE;
      end
      S_RESULT: begin
        ctrl.finish = 1'b1;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: hdl/rnct_datapath.sv
`timescale 1ns / 1ps
module rnct_datapath #(
  parameter int TABLE_ENTRIES = 64,
  parameter int LABEL_BITS    = 16,
  parameter int COUNT_BITS    = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  rnct_pkg::ctrl_t                       ctrl,
  output rnct_pkg::stat_t                       stat,
  input  logic [rnct_pkg::CMD_BITS-1:0]         cmd,
  input  logic [LABEL_BITS-1:0]                 subject_label,
  input  logic [rnct_pkg::COORD_BITS-1:0]       pixel_x,
  input  logic [rnct_pkg::COORD_BITS-1:0]       pixel_y,
  input  logic [LABEL_BITS-1:0]                 left_label,
  input  logic [LABEL_BITS-1:0]                 up_label,
  input  logic [LABEL_BITS-1:0]                 right_label,
  input  logic [LABEL_BITS-1:0]                 down_label,
  input  logic                                  cfg_write,
  input  logic [rnct_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [rnct_pkg::DIM_BITS-1:0]         cfg_data,
  output logic                                  done,
  output logic [rnct_pkg::STATUS_BITS-1:0]      status,
  output logic [$clog2(TABLE_ENTRIES+1)-1:0]    entries_used,
  output logic                                  no_neighbors
);
  import rnct_pkg::*;

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int USED_W = $clog2(TABLE_ENTRIES + 1);
  localparam int WORD_W = LABEL_BITS + COUNT_BITS;
  localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Configuration registers.
  logic [DIM_BITS-1:0] image_width;
  logic [DIM_BITS-1:0] image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      if (cfg_index == REG_IMAGE_WIDTH) begin
        image_width <= cfg_data;
      end else if (cfg_index == REG_IMAGE_HEIGHT) begin
        image_height <= cfg_data;
      end
    end
  end

  // Decode of the command into a list of up to four table operations.
  logic [LABEL_BITS-1:0] nl [4];
  logic [3:0]            nv;
  logic [3:0]            eq;
  logic [3:0]            take;
  logic [2:0]            eq_cnt;
  logic [3:0]            pend_load;
  logic                  remove_load;

  always_comb begin
    nl[0] = left_label;
    nl[1] = up_label;
    nl[2] = right_label;
    nl[3] = down_label;
    nv[0] = (pixel_x != '0);
    nv[1] = (pixel_y != '0);
    nv[2] = ({1'b0, pixel_x} + DIM_BITS'(1)) < image_width;
    nv[3] = ({1'b0, pixel_y} + DIM_BITS'(1)) < image_height;
    for (int i = 0; i < 4; i++) begin
      eq[i]   = nv[i] && (nl[i] == subject_label);
      take[i] = nv[i] && (nl[i] != subject_label);
      for (int j = 0; j < i; j++) begin
        if (nv[j] && (nl[j] == nl[i])) begin
          take[i] = 1'b0;
        end
      end
    end
    eq_cnt = 3'($countones(eq));
  end

  always_comb begin
    pend_load   = 4'b0000;
    remove_load = 1'b0;
    unique case (cmd)
      CMD_ADD:      pend_load = 4'b0001;
      CMD_REMOVE: begin
        pend_load   = 4'b0001;
        remove_load = 1'b1;
      end
      CMD_ADD_SELF: pend_load = take;
      CMD_ADD_CHK:  pend_load = (eq_cnt == 3'd1) ? 4'b0001 : 4'b0000;
      CMD_REM_CHK: begin
        pend_load   = (eq_cnt == 3'd0) ? 4'b0001 : 4'b0000;
        remove_load = 1'b1;
      end
      default:      pend_load = 4'b0000;
    endcase
  end

  logic [LABEL_BITS-1:0]  op_lab [4];
  logic [3:0]             pend;
  logic                   op_remove;
  logic                   is_clear;
  logic [1:0]             cur_slot;
  logic [1:0]             sel_slot;
  logic [STATUS_BITS-1:0] status_acc;

  always_comb begin
    if (pend[0]) begin
      sel_slot = 2'd0;
    end else if (pend[1]) begin
      sel_slot = 2'd1;
    end else if (pend[2]) begin
      sel_slot = 2'd2;
    end else begin
      sel_slot = 2'd3;
    end
  end

  // Table storage: label and count share one word; valid bits are flip-flops.
  logic [WORD_W-1:0]        mem [TABLE_ENTRIES];
  logic [WORD_W-1:0]        rd_data;
  logic [TABLE_ENTRIES-1:0] entry_valid;
  logic [USED_W-1:0]        used;

  logic [IDX_W-1:0]      raddr;
  logic                  issuing;
  logic                  rd_pend;
  logic [IDX_W-1:0]      rd_idx;
  logic                  found;
  logic [IDX_W-1:0]      found_idx;
  logic [COUNT_BITS-1:0] found_cnt;
  logic                  free_found;
  logic [IDX_W-1:0]      free_idx;

  logic [LABEL_BITS-1:0] op_label;
  logic                  hit;
  logic                  is_free;

  assign op_label = op_lab[cur_slot];
  assign hit      = rd_pend && entry_valid[rd_idx] &&
                    (rd_data[WORD_W-1:COUNT_BITS] == op_label);
  assign is_free  = rd_pend && !entry_valid[rd_idx];

  assign stat.is_clear   = is_clear;
  assign stat.op_pending = (pend != 4'b0000);
  assign stat.scan_done  = rd_pend && (hit || (rd_idx == LAST_IDX));

  // Update of the table at the end of one operation's scan.
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_wa;
  logic [WORD_W-1:0]      mem_wd;
  logic [COUNT_BITS-1:0]  cnt_dec;
  logic [COUNT_BITS-1:0]  cnt_inc;

  assign cnt_dec = found_cnt - COUNT_BITS'(1);
  assign cnt_inc = (found_cnt == COUNT_MAX) ? found_cnt : found_cnt + COUNT_BITS'(1);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = found_idx;
    mem_wd = {op_label, cnt_inc};
    if (ctrl.apply) begin
      if (found) begin
        mem_we = 1'b1;
        mem_wd = {op_label, op_remove ? cnt_dec : cnt_inc};
      end else if (!op_remove && free_found) begin
        mem_we = 1'b1;
        mem_wa = free_idx;
        mem_wd = {op_label, COUNT_BITS'(1)};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (ctrl.scan_en && issuing) begin
      rd_data <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      for (int i = 0; i < 4; i++) begin
        op_lab[i] <= (cmd == CMD_ADD_SELF) ? nl[i] : subject_label;
      end
    end
    if (ctrl.op_begin) begin
      raddr <= '0;
    end else if (ctrl.scan_en && issuing && (raddr != LAST_IDX)) begin
      raddr <= raddr + IDX_W'(1);
    end
    if (ctrl.scan_en) begin
      rd_idx <= raddr;
      if (rd_pend) begin
        found_idx <= rd_idx;
        found_cnt <= rd_data[COUNT_BITS-1:0];
      end
      if (is_free && !free_found) begin
        free_idx <= rd_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend        <= 4'b0000;
      op_remove   <= 1'b0;
      is_clear    <= 1'b0;
      cur_slot    <= 2'd0;
      status_acc  <= ST_OK;
      issuing     <= 1'b0;
      rd_pend     <= 1'b0;
      found       <= 1'b0;
      free_found  <= 1'b0;
      entry_valid <= '0;
      used        <= '0;
    end else begin
      if (ctrl.load) begin
        pend       <= pend_load;
        op_remove  <= remove_load;
        is_clear   <= (cmd == CMD_CLEAR);
        status_acc <= ST_OK;
      end
      if (ctrl.clear) begin
        entry_valid <= '0;
        used        <= '0;
      end
      if (ctrl.op_begin) begin
        cur_slot   <= sel_slot;
        issuing    <= 1'b1;
        rd_pend    <= 1'b0;
        found      <= 1'b0;
        free_found <= 1'b0;
      end else if (ctrl.scan_en) begin
        rd_pend <= issuing;
        if (issuing && (raddr == LAST_IDX)) begin
          issuing <= 1'b0;
        end
        if (rd_pend) begin
          found <= hit;
        end
        if (is_free) begin
          free_found <= 1'b1;
        end
      end
      if (ctrl.apply) begin
        pend[cur_slot] <= 1'b0;
        if (op_remove) begin
          if (!found) begin
            status_acc <= ST_ABSENT;
          end else if (cnt_dec == '0) begin
            entry_valid[found_idx] <= 1'b0;
            used                   <= used - USED_W'(1);
          end
        end else if (!found) begin
          if (free_found) begin
            entry_valid[free_idx] <= 1'b1;
            used                  <= used + USED_W'(1);
          end else begin
            status_acc <= ST_FULL;
          end
        end
      end
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.finish;
    end
    if (ctrl.finish) begin
      status       <= status_acc;
      entries_used <= used;
      no_neighbors <= (used == '0);
    end
  end

endmodule

FILE: hdl/region_neighbor_count_table_top.sv
`timescale 1ns / 1ps
// Neighbor count table of one image region.
// Command channel: drive cmd, subject_label, pixel_x/pixel_y and the four
// neighbor labels, and raise start; the transaction is taken at a clock edge
// with start high and busy low. Busy stays high while the command runs.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data write the
// image width (index 0) and height (index 1); cfg_ready is always high and
// writes are meant to happen while busy is low.
// Result: done is high for one cycle with status, entries_used and
// no_neighbors. The receiver cannot stall; each result is shown once.
// Timing: each table operation scans the label memory one entry per cycle
// through its single read port, stopping at a matching label. A command runs
// zero to four operations (add self up to four). Busy drops as done rises,
// so the next command can be taken in the cycle of the result.
// Reset: rst (synchronous) empties the table, sets width 640 and height 480.
module region_neighbor_count_table_top #(
  parameter int TABLE_ENTRIES = 64,
  parameter int LABEL_BITS    = 16,
  parameter int COUNT_BITS    = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [rnct_pkg::CMD_BITS-1:0]         cmd,
  input  logic [LABEL_BITS-1:0]                 subject_label,
  input  logic [rnct_pkg::COORD_BITS-1:0]       pixel_x,
  input  logic [rnct_pkg::COORD_BITS-1:0]       pixel_y,
  input  logic [LABEL_BITS-1:0]                 left_label,
  input  logic [LABEL_BITS-1:0]                 up_label,
  input  logic [LABEL_BITS-1:0]                 right_label,
  input  logic [LABEL_BITS-1:0]                 down_label,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [rnct_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [rnct_pkg::DIM_BITS-1:0]         cfg_data,
  output logic                                  done,
  output logic [rnct_pkg::STATUS_BITS-1:0]      status,
  output logic [$clog2(TABLE_ENTRIES+1)-1:0]    entries_used,
  output logic                                  no_neighbors
);
  import rnct_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  assign cfg_ready = 1'b1;

  rnct_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  rnct_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .LABEL_BITS    (LABEL_BITS),
    .COUNT_BITS    (COUNT_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .stat          (stat),
    .cmd           (cmd),
    .subject_label (subject_label),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .left_label    (left_label),
    .up_label      (up_label),
    .right_label   (right_label),
    .down_label    (down_label),
    .cfg_write     (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .done          (done),
    .status        (status),
    .entries_used  (entries_used),
    .no_neighbors  (no_neighbors)
  );

endmodule

FILE: tb/neighbor_table_checker.sv
`timescale 1ns / 1ps
module neighbor_table_checker #(
  parameter int TABLE_ENTRIES = 64,
  parameter int LABEL_BITS    = 16,
  parameter int COUNT_BITS    = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic                                  busy,
  input  logic [rnct_pkg::CMD_BITS-1:0]         cmd,
  input  logic [LABEL_BITS-1:0]                 subject_label,
  input  logic [rnct_pkg::COORD_BITS-1:0]       pixel_x,
  input  logic [rnct_pkg::COORD_BITS-1:0]       pixel_y,
  input  logic [LABEL_BITS-1:0]                 left_label,
  input  logic [LABEL_BITS-1:0]                 up_label,
  input  logic [LABEL_BITS-1:0]                 right_label,
  input  logic [LABEL_BITS-1:0]                 down_label,
  input  logic                                  cfg_valid,
  input  logic                                  cfg_ready,
  input  logic [rnct_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [rnct_pkg::DIM_BITS-1:0]         cfg_data,
  input  logic                                  done,
  input  logic [rnct_pkg::STATUS_BITS-1:0]      status,
  input  logic [$clog2(TABLE_ENTRIES+1)-1:0]    entries_used,
  input  logic                                  no_neighbors,
  output int                                    pending_results,
  output int                                    mismatch_count
);
  import rnct_pkg::*;

  localparam int USED_BITS = $clog2(TABLE_ENTRIES + 1);
  localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [USED_BITS-1:0]   used;
    logic                   empty;
  } table_outcome_t;

  logic [LABEL_BITS-1:0] slot_label [TABLE_ENTRIES];
  logic [COUNT_BITS-1:0] slot_count [TABLE_ENTRIES];
  bit                    slot_valid [TABLE_ENTRIES];
  int                    slots_used;
  logic [DIM_BITS-1:0]   image_w;
  logic [DIM_BITS-1:0]   image_h;
  table_outcome_t        outcome_q [$];
  int                    errors = 0;

  function automatic int locate(logic [LABEL_BITS-1:0] lab);
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (slot_valid[i] && slot_label[i] == lab) return i;
    return TABLE_ENTRIES;
  endfunction

  function automatic logic [STATUS_BITS-1:0] count_up(logic [LABEL_BITS-1:0] lab);
    int i;
    i = locate(lab);
    if (i < TABLE_ENTRIES) begin
      if (slot_count[i] != COUNT_TOP) slot_count[i] = slot_count[i] + 1'b1;
      return ST_OK;
    end
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      if (!slot_valid[k]) begin
        slot_valid[k] = 1'b1;
        slot_label[k] = lab;
        slot_count[k] = COUNT_BITS'(1);
        slots_used++;
        return ST_OK;
      end
    end
    return ST_FULL;
  endfunction

  function automatic logic [STATUS_BITS-1:0] count_down(logic [LABEL_BITS-1:0] lab);
    int i;
    i = locate(lab);
    if (i >= TABLE_ENTRIES) return ST_ABSENT;
    slot_count[i] = slot_count[i] - 1'b1;
    if (slot_count[i] == 0) begin
      slot_valid[i] = 1'b0;
      slots_used--;
    end
    return ST_OK;
  endfunction

  function automatic table_outcome_t predict(logic [CMD_BITS-1:0] op,
                                             logic [LABEL_BITS-1:0] subj,
                                             logic [COORD_BITS-1:0] px,
                                             logic [COORD_BITS-1:0] py,
                                             logic [3:0][LABEL_BITS-1:0] nb);
    logic [3:0]             nv;
    int                     hit_count;
    bit                     take;
    logic [STATUS_BITS-1:0] st;
    table_outcome_t         r;
    st = ST_OK;
    // Neighbor order is left, up, right, down.
    nv[0] = px != 0;
    nv[1] = py != 0;
    nv[2] = (int'(px) + 1) < int'(image_w);
    nv[3] = (int'(py) + 1) < int'(image_h);
    hit_count = 0;
    for (int i = 0; i < 4; i++)
      if (nv[i] && nb[i] == subj) hit_count++;
    case (op)
      CMD_ADD: st = count_up(subj);
      CMD_REMOVE: st = count_down(subj);
      CMD_ADD_SELF: begin
        for (int i = 0; i < 4; i++) begin
          take = nv[i] && nb[i] != subj;
          for (int j = 0; j < i; j++)
            if (nv[j] && nb[j] == nb[i]) take = 0;
          if (take && count_up(nb[i]) == ST_FULL) st = ST_FULL;
        end
      end
      CMD_ADD_CHK: if (hit_count == 1) st = count_up(subj);
      CMD_REM_CHK: if (hit_count == 0) st = count_down(subj);
      CMD_CLEAR: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) slot_valid[i] = 1'b0;
        slots_used = 0;
      end
      default: ;
    endcase
    r.status = st;
    r.used   = USED_BITS'(slots_used);
    r.empty  = slots_used == 0;
    return r;
  endfunction

  task automatic flag_mismatch(string field, logic [31:0] want_v, logic [31:0] got_v);
    errors++;
    $error("%s mismatch: expected %0d, actual %0d", field, want_v, got_v);
  endtask

  always @(posedge clk) begin
    table_outcome_t want;
    if (rst) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) slot_valid[i] = 1'b0;
      slots_used = 0;
      image_w = WIDTH_RESET;
      image_h = HEIGHT_RESET;
      outcome_q.delete();
    end else begin
      if (done) begin
        if (outcome_q.size() == 0) begin
          errors++;
          $error("result transaction with no command outstanding");
        end else begin
          want = outcome_q.pop_front();
          if (status !== want.status)
            flag_mismatch("status", 32'(want.status), 32'(status));
          if (entries_used !== want.used)
            flag_mismatch("entries_used", 32'(want.used), 32'(entries_used));
          if (no_neighbors !== want.empty)
            flag_mismatch("no_neighbors", 32'(want.empty), 32'(no_neighbors));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_IMAGE_WIDTH) image_w = cfg_data;
        else if (cfg_index == REG_IMAGE_HEIGHT) image_h = cfg_data;
      end
      if (start && !busy)
        outcome_q.push_back(predict(cmd, subject_label, pixel_x, pixel_y,
                                    {down_label, right_label, up_label, left_label}));
    end
    pending_results <= outcome_q.size();
    mismatch_count  <= errors;
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import rnct_pkg::*;

  localparam int TABLE_ENTRIES = 64;
  localparam int LABEL_BITS    = 16;
  localparam int COUNT_BITS    = 16;
  localparam int USED_BITS     = $clog2(TABLE_ENTRIES + 1);
  localparam int OP_WORST      = 3 + 4 * (TABLE_ENTRIES + 3);
  localparam longint CYCLE_LIMIT = 64'd4 * 1000 * (OP_WORST + 8);

  // Codes outside the documented sets; the block must ignore them.
  localparam logic [CMD_BITS-1:0]       CMD_UNUSED_6 = 3'd6;
  localparam logic [CMD_BITS-1:0]       CMD_UNUSED_7 = 3'd7;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_2  = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_3  = 2'd3;

  typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX} traffic_mode_t;

  typedef struct packed {
    logic [CMD_BITS-1:0]        op;
    logic [LABEL_BITS-1:0]      subj;
    logic [COORD_BITS-1:0]      x;
    logic [COORD_BITS-1:0]      y;
    logic [3:0][LABEL_BITS-1:0] nb;  // left, up, right, down
  } table_cmd_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic [CMD_BITS-1:0]       cmd = CMD_ADD;
  logic [LABEL_BITS-1:0]     subject_label = '0;
  logic [COORD_BITS-1:0]     pixel_x = '0;
  logic [COORD_BITS-1:0]     pixel_y = '0;
  logic [LABEL_BITS-1:0]     left_label = '0;
  logic [LABEL_BITS-1:0]     up_label = '0;
  logic [LABEL_BITS-1:0]     right_label = '0;
  logic [LABEL_BITS-1:0]     down_label = '0;
  logic                      cfg_valid = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_IMAGE_WIDTH;
  logic [DIM_BITS-1:0]       cfg_data = '0;
  logic                      busy;
  logic                      cfg_ready;
  logic                      done;
  logic [STATUS_BITS-1:0]    status;
  logic [USED_BITS-1:0]      entries_used;
  logic                      no_neighbors;
  int                        pending_results;
  int                        mismatch_count;

  int                    cur_w = int'(WIDTH_RESET);
  int                    cur_h = int'(HEIGHT_RESET);
  logic [LABEL_BITS-1:0] label_pool [$];
  longint                cycles = 0;

  region_neighbor_count_table_top #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .LABEL_BITS   (LABEL_BITS),
    .COUNT_BITS   (COUNT_BITS)
  ) i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .subject_label(subject_label), .pixel_x(pixel_x), .pixel_y(pixel_y),
    .left_label(left_label), .up_label(up_label), .right_label(right_label),
    .down_label(down_label), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done), .status(status),
    .entries_used(entries_used), .no_neighbors(no_neighbors)
  );

  neighbor_table_checker #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .LABEL_BITS   (LABEL_BITS),
    .COUNT_BITS   (COUNT_BITS)
  ) i_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .subject_label(subject_label), .pixel_x(pixel_x), .pixel_y(pixel_y),
    .left_label(left_label), .up_label(up_label), .right_label(right_label),
    .down_label(down_label), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done), .status(status),
    .entries_used(entries_used), .no_neighbors(no_neighbors),
    .pending_results(pending_results), .mismatch_count(mismatch_count)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic table_cmd_t make_cmd(logic [CMD_BITS-1:0] op, int subj, int x, int y,
                                          int l, int u, int r, int d);
    table_cmd_t c;
    c.op    = op;
    c.subj  = LABEL_BITS'(subj);
    c.x     = COORD_BITS'(x);
    c.y     = COORD_BITS'(y);
    c.nb[0] = LABEL_BITS'(l);
    c.nb[1] = LABEL_BITS'(u);
    c.nb[2] = LABEL_BITS'(r);
    c.nb[3] = LABEL_BITS'(d);
    return c;
  endfunction

  function automatic logic [LABEL_BITS-1:0] pick_label();
    if ($urandom_range(0, 9) == 0) return LABEL_BITS'($urandom_range(0, 65535));
    return label_pool[$urandom_range(0, label_pool.size() - 1)];
  endfunction

  // Coordinates cluster on the borders so that neighbor validity flips often.
  function automatic logic [COORD_BITS-1:0] pick_coord(int dim);
    int v;
    case ($urandom_range(0, 5))
      0: v = 0;
      1: v = dim - 1;
      2: v = dim - 2;
      3: v = (dim > 2) ? $urandom_range(1, (dim - 2 > 4095) ? 4095 : dim - 2) : 0;
      4: v = 4095;
      default: v = $urandom_range(0, 4095);
    endcase
    return v[COORD_BITS-1:0];
  endfunction

  function automatic table_cmd_t random_cmd(traffic_mode_t mode);
    table_cmd_t c;
    int roll;
    if ($urandom_range(0, 24) == 0) begin
      c.op   = CMD_BITS'($urandom_range(CMD_ADD, CMD_UNUSED_7));
      c.subj = LABEL_BITS'($urandom_range(0, 65535));
      c.x    = COORD_BITS'($urandom_range(0, 4095));
      c.y    = COORD_BITS'($urandom_range(0, 4095));
      for (int k = 0; k < 4; k++) c.nb[k] = LABEL_BITS'($urandom_range(0, 65535));
      return c;
    end
    roll = $urandom_range(0, 99);
    case (mode)
      MODE_FILL:
        c.op = (roll < 45) ? CMD_ADD : (roll < 80) ? CMD_ADD_SELF :
               (roll < 90) ? CMD_ADD_CHK : (roll < 95) ? CMD_REMOVE : CMD_REM_CHK;
      MODE_DRAIN:
        c.op = (roll < 50) ? CMD_REMOVE : (roll < 70) ? CMD_REM_CHK :
               (roll < 85) ? CMD_ADD : (roll < 95) ? CMD_ADD_CHK : CMD_ADD_SELF;
      default:
        c.op = (roll < 20) ? CMD_ADD : (roll < 40) ? CMD_REMOVE :
               (roll < 60) ? CMD_ADD_SELF : (roll < 75) ? CMD_ADD_CHK :
               (roll < 90) ? CMD_REM_CHK : (roll < 95) ? CMD_CLEAR :
               (roll < 97) ? CMD_UNUSED_6 : CMD_UNUSED_7;
    endcase
    c.subj = pick_label();
    c.x    = pick_coord(cur_w);
    c.y    = pick_coord(cur_h);
    // Neighbors often repeat the subject so the check commands see zero, one or more matches.
    for (int k = 0; k < 4; k++)
      c.nb[k] = ($urandom_range(0, 3) == 0) ? c.subj : pick_label();
    return c;
  endfunction

  // Start stays high across back-to-back transactions; it only drops for a gap.
  task automatic issue(table_cmd_t c, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd           <= c.op;
    subject_label <= c.subj;
    pixel_x       <= c.x;
    pixel_y       <= c.y;
    left_label    <= c.nb[0];
    up_label      <= c.nb[1];
    right_label   <= c.nb[2];
    down_label    <= c.nb[3];
    start         <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (pending_results != 0 || busy);
  endtask

  task automatic set_image_size(int w, int h);
    cfg_valid <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= DIM_BITS'(w);
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= DIM_BITS'(h);
    do @(posedge clk); while (!cfg_ready);
    // A write to a spare index must leave both registers alone.
    cfg_index <= $urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3;
    cfg_data  <= DIM_BITS'($urandom_range(0, 8191));
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_w = w;
    cur_h = h;
  endtask

  initial begin
    int                    pool_sizes [4];
    int                    fill_items;
    pool_sizes = '{96, 12, 40, 6};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset image size of 640 x 480.
    issue(make_cmd(CMD_REMOVE, 5, 100, 100, 1, 2, 3, 4), $urandom_range(0, 5));
    issue(make_cmd(CMD_ADD, 0, 100, 100, 1, 2, 3, 4), $urandom_range(0, 5));
    issue(make_cmd(CMD_ADD, 16'hFFFF, 100, 100, 1, 2, 3, 4), $urandom_range(0, 5));
    issue(make_cmd(CMD_ADD, 16'hFFFF, 100, 100, 1, 2, 3, 4), $urandom_range(0, 5));
    issue(make_cmd(CMD_REMOVE, 16'hFFFF, 100, 100, 1, 2, 3, 4), $urandom_range(0, 5));
    issue(make_cmd(CMD_REMOVE, 16'hFFFF, 100, 100, 1, 2, 3, 4), $urandom_range(0, 5));
    issue(make_cmd(CMD_ADD_SELF, 10, 0, 0, 11, 12, 13, 13), $urandom_range(0, 5));
    issue(make_cmd(CMD_ADD_SELF, 10, 100, 100, 10, 20, 20, 21), $urandom_range(0, 5));
    issue(make_cmd(CMD_ADD_SELF, 30, 639, 479, 31, 32, 33, 34), $urandom_range(0, 5));
    issue(make_cmd(CMD_ADD_CHK, 20, 100, 100, 20, 1, 2, 3), $urandom_range(0, 5));
    issue(make_cmd(CMD_ADD_CHK, 20, 100, 100, 20, 20, 2, 3), $urandom_range(0, 5));
    issue(make_cmd(CMD_ADD_CHK, 40, 100, 100, 1, 2, 3, 4), $urandom_range(0, 5));
    issue(make_cmd(CMD_ADD_CHK, 40, 0, 100, 40, 40, 3, 4), $urandom_range(0, 5));
    issue(make_cmd(CMD_REM_CHK, 20, 100, 100, 1, 2, 3, 4), $urandom_range(0, 5));
    issue(make_cmd(CMD_REM_CHK, 20, 100, 100, 20, 2, 3, 4), $urandom_range(0, 5));
    issue(make_cmd(CMD_REM_CHK, 99, 100, 100, 1, 2, 3, 4), $urandom_range(0, 5));
    issue(make_cmd(CMD_REM_CHK, 21, 639, 100, 1, 2, 21, 4), $urandom_range(0, 5));
    issue(make_cmd(CMD_UNUSED_6, 7, 100, 100, 1, 2, 3, 4), $urandom_range(0, 5));
    issue(make_cmd(CMD_UNUSED_7, 16'hFFFF, 4095, 4095, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                   16'hFFFF), $urandom_range(0, 5));
    issue(make_cmd(CMD_ADD_SELF, 49, 4095, 4095, 50, 51, 52, 53), $urandom_range(0, 5));
    issue(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0), $urandom_range(0, 5));
    issue(make_cmd(CMD_ADD, 16'h8000, 100, 100, 1, 2, 3, 4), $urandom_range(0, 5));
    issue(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0), $urandom_range(0, 5));
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: ;
        1: set_image_size(1, 1);
        2: set_image_size(4096, 4096);
        3: set_image_size(0, 0);
        4: set_image_size(8191, 8191);
        5: set_image_size(2, 3);
        6: set_image_size($urandom_range(1, 4096), $urandom_range(1, 4096));
        default: set_image_size($urandom_range(0, 8191), $urandom_range(0, 8191));
      endcase
      label_pool.delete();
      repeat (pool_sizes[p % 4]) label_pool.push_back(LABEL_BITS'($urandom_range(0, 65535)));
      // A wide pool with a long add run drives the table into the full state.
      fill_items = (pool_sizes[p % 4] > TABLE_ENTRIES) ? 75 : 45;
      repeat (fill_items) issue(random_cmd(MODE_FILL), $urandom_range(0, 5));
      repeat (30) issue(random_cmd(MODE_MIX), $urandom_range(0, 5));
      repeat (25) issue(random_cmd(MODE_DRAIN), $urandom_range(0, 5));
      wait_idle();
    end

    repeat (OP_WORST) @(posedge clk);
    if (mismatch_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
